// ===== design/assert_macros.svh =====
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define QIR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("qir: property violated");

// The expression must never be true outside reset.
`define QIR_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("qir: forbidden condition seen");

`endif

// ===== design/qir_pkg.sv =====
// Types and constants of the quadratic integer roots unit.
package qir_pkg;

  // Result status codes.
  localparam logic [1:0] ST_TWO_ROOTS = 2'd0;
  localparam logic [1:0] ST_ONE_ROOT  = 2'd1;
  localparam logic [1:0] ST_NO_ROOTS  = 2'd2;
  localparam logic [1:0] ST_INVALID   = 2'd3;

  // Smallest legal coefficient.
  localparam logic [7:0] COEF_MIN = 8'd2;

  // Cell counts: one root bit per square root cell, one quotient bit per divider cell.
  localparam int unsigned ROOT_W = 8;
  localparam int unsigned QUO_W  = 7;

  // Cycles from an accepted request to its result strobe.
  localparam int unsigned QIR_LATENCY = ROOT_W + QUO_W + 4;

  // Input request.
  typedef struct packed {
    logic [7:0] coef_a;
    logic [7:0] coef_b;
    logic [7:0] coef_c;
  } qir_in_t;

  // Result.
  typedef struct packed {
    logic [1:0]        root_status;
    logic signed [7:0] first_root;
    logic signed [7:0] second_root;
  } qir_out_t;

  // Data handed between square root cells.
  typedef struct packed {
    logic              valid;
    logic [1:0]        status;
    logic [7:0]        coef_b;
    logic [8:0]        denom;
    logic [15:0]       rem;
    logic [ROOT_W-1:0] root;
  } qir_sqrt_t;

  // Data handed between divider cells.
  typedef struct packed {
    logic             valid;
    logic [1:0]       status;
    logic [8:0]       denom;
    logic [8:0]       rem_lo;
    logic [8:0]       rem_hi;
    logic [QUO_W-1:0] quo_lo;
    logic [QUO_W-1:0] quo_hi;
  } qir_div_t;

endpackage

// ===== design/qir_sqrt_cell.sv =====
// One cell of the square root chain: decides one root bit per cycle.
module qir_sqrt_cell
  import qir_pkg::*;
#(
  parameter int unsigned BIT = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  qir_sqrt_t st_i,
  output qir_sqrt_t st_o
);

  qir_sqrt_t  st_r;
  qir_sqrt_t  st_nxt;
  logic [16:0] trial;

  // Growth of root^2 when this bit is set: root * 2^(BIT+1) + 2^(2*BIT).
  assign trial = (17'(st_i.root) << (BIT + 1)) + (17'd1 << (2 * BIT));

  // Keep the bit if the remainder covers the growth.
  always_comb begin
    st_nxt = st_i;
    if ({1'b0, st_i.rem} >= trial) begin
      st_nxt.rem  = st_i.rem - trial[15:0];
      st_nxt.root = st_i.root | (ROOT_W'(1) << BIT);
    end
  end

  // Only the valid flag needs a reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign st_o = st_r;

endmodule

// ===== design/qir_div_cell.sv =====
// One cell of the divider chain: decides one quotient bit of both roots per cycle.
module qir_div_cell
  import qir_pkg::*;
#(
  parameter int unsigned BIT = 0
) (
  input  logic     clk,
  input  logic     rst_n,
  input  qir_div_t st_i,
  output qir_div_t st_o
);

  qir_div_t    st_r;
  qir_div_t    st_nxt;
  logic [15:0] trial;

  // Divisor aligned to this quotient bit.
  assign trial = 16'(st_i.denom) << BIT;

  // Restoring step on both dividends at once.
  always_comb begin
    st_nxt = st_i;
    if ({7'd0, st_i.rem_lo} >= trial) begin
      st_nxt.rem_lo = st_i.rem_lo - trial[8:0];
      st_nxt.quo_lo = st_i.quo_lo | (QUO_W'(1) << BIT);
    end
    if ({7'd0, st_i.rem_hi} >= trial) begin
      st_nxt.rem_hi = st_i.rem_hi - trial[8:0];
      st_nxt.quo_hi = st_i.quo_hi | (QUO_W'(1) << BIT);
    end
  end

  // Only the valid flag needs a reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign st_o = st_r;

endmodule

// ===== design/quadratic_integer_roots_unit.sv =====
// Top level of the quadratic integer roots unit.
//
//  Channel   Ports                  Handshake
//  --------  ---------------------  ----------------------------------------
//  request   start, busy, in_data   taken at an edge with start high, busy low
//  result    out_strobe, out_data   shown for one cycle, cannot be held off
//
// A request is taken every cycle; busy is tied low.
// Each result passes from its request through the product register, the discriminant
// register, eight square root cells, the dividend register, seven divider cells
// and one output register.
// Synchronous active-low reset empties the pipeline; no result is in flight after it.
// The receiver cannot stall, so the chain advances every cycle.
module quadratic_integer_roots_unit
  import qir_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  qir_in_t  in_data,
  output logic     out_strobe,
  output qir_out_t out_data
);

  // Product stage.
  logic        s1_valid_r;
  logic        s1_ok_r;
  logic [7:0]  s1_b_r;
  logic [8:0]  s1_denom_r;
  logic [15:0] s1_bsq_r;
  logic [17:0] s1_fac_r;

  // Chains of cells.
  qir_sqrt_t sq_chain [0:ROOT_W];
  qir_div_t  dv_chain [0:QUO_W];

  // Registers at the chain heads and the output.
  qir_sqrt_t sq_head_r;
  qir_sqrt_t sq_head_nxt;
  qir_div_t  dv_head_r;
  qir_div_t  dv_head_nxt;
  qir_out_t  out_r;
  qir_out_t  out_nxt;
  logic      out_strobe_r;

  // Dividend forming.
  logic [8:0] s_ceil;
  logic [8:0] b_ext;

  // The pipeline takes a request in every cycle.
  assign busy = 1'b0;

  // Coefficient check, B*B and 4*A*C.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start && !busy;
      s1_ok_r    <= (in_data.coef_a >= COEF_MIN) && (in_data.coef_b >= COEF_MIN) &&
                    (in_data.coef_c >= COEF_MIN);
      s1_b_r     <= in_data.coef_b;
      s1_denom_r <= {in_data.coef_a, 1'b0};
      s1_bsq_r   <= 16'(in_data.coef_b) * 16'(in_data.coef_b);
      s1_fac_r   <= {(16'(in_data.coef_a) * 16'(in_data.coef_c)), 2'b00};
    end
  end

  // Discriminant sign and value.
  always_comb begin
    sq_head_nxt        = '0;
    sq_head_nxt.valid  = s1_valid_r;
    sq_head_nxt.coef_b = s1_b_r;
    sq_head_nxt.denom  = s1_denom_r;
    if (!s1_ok_r) begin
      sq_head_nxt.status = ST_INVALID;
    end else if ({2'b00, s1_bsq_r} > s1_fac_r) begin
      sq_head_nxt.status = ST_TWO_ROOTS;
      sq_head_nxt.rem    = s1_bsq_r - s1_fac_r[15:0];
    end else if ({2'b00, s1_bsq_r} == s1_fac_r) begin
      sq_head_nxt.status = ST_ONE_ROOT;
    end else begin
      sq_head_nxt.status = ST_NO_ROOTS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_head_r.valid <= 1'b0;
    end else begin
      sq_head_r <= sq_head_nxt;
    end
  end

  assign sq_chain[0] = sq_head_r;

  // Square root cells, most significant root bit first.
  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    qir_sqrt_cell #(
      .BIT(ROOT_W - 1 - i)
    ) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .st_i (sq_chain[i]),
      .st_o (sq_chain[i+1])
    );
  end

  // Ceiling root and the two dividends B + floor(sqrt) and B - ceil(sqrt).
  assign b_ext  = {1'b0, sq_chain[ROOT_W].coef_b};
  assign s_ceil = {1'b0, sq_chain[ROOT_W].root} + {8'd0, (sq_chain[ROOT_W].rem != 16'd0)};

  always_comb begin
    dv_head_nxt        = '0;
    dv_head_nxt.valid  = sq_chain[ROOT_W].valid;
    dv_head_nxt.status = sq_chain[ROOT_W].status;
    dv_head_nxt.denom  = sq_chain[ROOT_W].denom;
    dv_head_nxt.rem_lo = b_ext + {1'b0, sq_chain[ROOT_W].root};
    if (b_ext >= s_ceil) begin
      dv_head_nxt.rem_hi = b_ext - s_ceil;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_head_r.valid <= 1'b0;
    end else begin
      dv_head_r <= dv_head_nxt;
    end
  end

  assign dv_chain[0] = dv_head_r;

  // Divider cells, most significant quotient bit first.
  for (genvar j = 0; j < QUO_W; j++) begin : g_div
    qir_div_cell #(
      .BIT(QUO_W - 1 - j)
    ) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .st_i (dv_chain[j]),
      .st_o (dv_chain[j+1])
    );
  end

  // Negate the quotients and zero the fields that the status leaves unused.
  always_comb begin
    out_nxt             = '0;
    out_nxt.root_status = dv_chain[QUO_W].status;
    case (dv_chain[QUO_W].status)
      ST_TWO_ROOTS: begin
        out_nxt.first_root  = 8'd0 - {1'b0, dv_chain[QUO_W].quo_lo};
        out_nxt.second_root = 8'd0 - {1'b0, dv_chain[QUO_W].quo_hi};
      end
      ST_ONE_ROOT: begin
        out_nxt.first_root = 8'd0 - {1'b0, dv_chain[QUO_W].quo_lo};
      end
      default: begin
        out_nxt.first_root = 8'sd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= dv_chain[QUO_W].valid;
      out_r        <= out_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

endmodule

// ===== design/qir_checker.sv =====
// Port-level checker for the quadratic integer roots unit, bound to the top level.
`include "assert_macros.svh"

module qir_checker
  import qir_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_strobe,
  input qir_out_t out_data
);

  // Every accepted request gives one result after the fixed latency.
  `QIR_ASSERT(a_req_gives_result, (start && !busy) |-> ##QIR_LATENCY out_strobe)

  // No result appears without a request that latency earlier.
  `QIR_ASSERT(a_result_has_req, out_strobe |-> $past(start && !busy, QIR_LATENCY))

  // The second root reads as zero for every status but two roots.
  `QIR_ASSERT_NEVER(a_unused_roots_zero, out_strobe &&
    (out_data.root_status != ST_TWO_ROOTS) && (out_data.second_root != 8'sd0))

  // The smaller root comes first.
  `QIR_ASSERT_NEVER(a_roots_ordered, out_strobe &&
    (out_data.root_status == ST_TWO_ROOTS) && (out_data.first_root > out_data.second_root))

  // An invalid coefficient gives no root value.
  `QIR_ASSERT_NEVER(a_invalid_zero, out_strobe &&
    (out_data.root_status == ST_INVALID) && (out_data.first_root != 8'sd0))

endmodule

bind quadratic_integer_roots_unit qir_checker u_qir_checker (.*);
